@@ rtl/utt_pkg.sv @@
// UTF-16 to UTF-8 transcoder: shared types, constants and the UTF-8 encoder.
// Used by the front, back and queue modules and by the top level.
// No dependencies.
package utt_pkg;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Lim1Byte  = 21'h80;
  localparam logic [20:0] Lim2Byte  = 21'h800;
  localparam logic [20:0] Lim3Byte  = 21'h10000;
  localparam logic [5:0]  HighTag   = 6'b110110;

  localparam logic [2:0] Lead2 = 3'b110;
  localparam logic [3:0] Lead3 = 4'b1110;
  localparam logic [4:0] Lead4 = 5'b11110;
  localparam logic [1:0] Cont  = 2'b10;

  localparam int unsigned MaxBytes = 6;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } enc_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     last;
  } job_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < Lim1Byte) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp < Lim2Byte) begin
      e.b[0] = {Lead2, cp[10:6]};
      e.b[1] = {Cont, cp[5:0]};
      e.len  = 3'd2;
    end else if (cp < Lim3Byte) begin
      e.b[0] = {Lead3, cp[15:12]};
      e.b[1] = {Cont, cp[11:6]};
      e.b[2] = {Cont, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = {Lead4, cp[20:18]};
      e.b[1] = {Cont, cp[17:12]};
      e.b[2] = {Cont, cp[11:6]};
      e.b[3] = {Cont, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

@@ rtl/utt_if.sv @@
// Valid/ready channel interfaces of the transcoder: code units in, bytes out.
// No dependencies.
interface utt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface utt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_item;
  logic       end_of_string;

  modport source (output valid, output out_byte, output byte_valid,
                  output last_of_item, output end_of_string, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input last_of_item, input end_of_string, output ready);
endinterface

@@ rtl/utf16_to_utf8_transcoder.sv @@
// UTF-16 code unit to UTF-8 byte stream transcoder, top level.
// Depends on utt_pkg, utt_if, utt_front, utt_queue and utt_back.
//
// in_ch carries one UTF-16 code unit per transfer with last_unit marking the
// end of a string. out_ch carries one UTF-8 byte per transfer; last_of_item
// flags the final byte caused by an input unit and end_of_string the final
// byte of the string. A last unit that yields no bytes produces one bare
// marker with byte_valid low and out_byte zero. A unit that yields nothing
// else (held high surrogate, terminator, units after the terminator) produces
// no transfer.
// When the block is idle, the job of a unit is written into a queue slot and
// then into the back end's job register, from which its first byte is offered.
// Throughput: one byte per cycle on out_ch while jobs are queued and out_ch.ready
// is high; a unit yields at most 6 bytes. The back end byte serialiser sets this rate.
// The front end takes a new unit every cycle while the job queue has room,
// so input keeps flowing while a byte waits on a stalled receiver; once the
// queue is full in_ch.ready drops until out_ch.ready frees a slot.
// Reset (rst_n low, synchronous) clears the surrogate and terminator state,
// empties the queue and drops out_ch.valid.
module utf16_to_utf8_transcoder import utt_pkg::*; #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  utt_in_if.sink    in_ch,
  utt_out_if.source out_ch
);

  job_t push_job, pop_job;
  logic push_valid, push_ready, pop_valid, pop_ready;

  utt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  utt_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  utt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

@@ rtl/utt_front.sv @@
// Front end: accepts code units, tracks surrogate and terminator state,
// and forms a byte job for the queue. Depends on utt_pkg and utt_in_if.
module utt_front import utt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  utt_in_if.sink        in_ch,
  output job_t          push_job,
  output logic          push_valid,
  input  logic          push_ready
);

  logic       pend_r, pend_nxt;
  logic [9:0] hi_r, hi_nxt;
  logic       stop_r, stop_nxt;
  logic       is_high, is_low, done, accept;
  enc_t       held_e, pair_e, new_e;
  job_t       job;

  assign is_high = in_ch.code_unit inside {[HighFirst:HighLast]};
  assign is_low  = in_ch.code_unit inside {[LowFirst:LowLast]};

  assign held_e = utf8_encode({5'd0, HighTag, hi_r});
  assign pair_e = utf8_encode(SuppBase + {1'b0, hi_r, in_ch.code_unit[9:0]});
  assign new_e  = utf8_encode({5'd0, in_ch.code_unit});

  always_comb begin
    job      = '0;
    pend_nxt = pend_r;
    hi_nxt   = hi_r;
    stop_nxt = stop_r;
    done     = 1'b0;
    if (!stop_r) begin
      if (pend_r) begin
        if (is_low) begin
          job.bytes[3:0] = pair_e.b;
          job.count      = 3'd4;
          done           = 1'b1;
        end else begin
          job.bytes[2:0] = held_e.b[2:0];
          job.count      = 3'd3;
        end
        pend_nxt = 1'b0;
        hi_nxt   = '0;
      end
      if (!done) begin
        if (is_high && !in_ch.last_unit) begin
          pend_nxt = 1'b1;
          hi_nxt   = in_ch.code_unit[9:0];
        end else if (in_ch.code_unit == '0) begin
          stop_nxt = 1'b1;
        end else if (pend_r) begin
          job.bytes[5:3] = new_e.b[2:0];
          job.count      = 3'd3 + new_e.len;
        end else begin
          job.bytes[3:0] = new_e.b;
          job.count      = new_e.len;
        end
      end
    end
    job.last = in_ch.last_unit;
    if (in_ch.last_unit) begin
      pend_nxt = 1'b0;
      hi_nxt   = '0;
      stop_nxt = 1'b0;
    end
  end

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = push_ready;
  assign push_job    = job;
  assign push_valid  = in_ch.valid && ((job.count != 3'd0) || job.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      hi_r   <= '0;
      stop_r <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      hi_r   <= hi_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

@@ rtl/utt_queue.sv @@
// Short job queue between front and back end of the transcoder.
// Depends on utt_pkg.
module utt_queue import utt_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  job_t push_job,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_job,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slot_r [DEPTH];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] cnt_r;
  logic            push, pop;

  assign push_ready = cnt_r != CntW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = slot_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/utt_back.sv @@
// Back end: holds one job and sends its bytes one per transfer.
// Depends on utt_pkg and utt_out_if.
module utt_back import utt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  job_t    pop_job,
  input  logic    pop_valid,
  output logic    pop_ready,
  utt_out_if.source out_ch
);

  job_t       cur_r;
  logic [2:0] idx_r;
  logic       act_r;
  logic       final_byte, sent;

  assign final_byte = (cur_r.count == 3'd0) || (idx_r == cur_r.count - 3'd1);
  assign sent       = out_ch.valid && out_ch.ready;
  assign pop_ready  = !act_r || (sent && final_byte);

  assign out_ch.valid         = act_r;
  assign out_ch.byte_valid    = cur_r.count != 3'd0;
  assign out_ch.out_byte      = (cur_r.count != 3'd0) ? cur_r.bytes[idx_r] : 8'd0;
  assign out_ch.last_of_item  = final_byte;
  assign out_ch.end_of_string = final_byte && cur_r.last;

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
    end else if (pop_ready) begin
      act_r <= pop_valid;
      idx_r <= '0;
    end else if (sent) begin
      idx_r <= idx_r + 3'd1;
    end
  end

endmodule

@@ rtl/utt_checker.sv @@
// Port-level checks for the transcoder and the bind that attaches them.
// Depends on utf16_to_utf8_transcoder.
module utt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       last_of_item,
  input logic       end_of_string
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transfer withdrawn");

  a_end_marks_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_string |-> last_of_item)
    else $error("end of string without end of item");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> end_of_string && (out_byte == 8'd0))
    else $error("bare marker malformed");

endmodule

bind utf16_to_utf8_transcoder utt_checker u_utt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .byte_valid    (out_ch.byte_valid),
  .last_of_item  (out_ch.last_of_item),
  .end_of_string (out_ch.end_of_string)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for utf16_to_utf8_transcoder: directed and random UTF-16 strings are
// driven in, and every UTF-8 byte out is checked by a transcoding scoreboard.
// Depends on utt_if and the transcoder RTL.
module tb;

  typedef struct {
    logic [7:0] data;
    logic       data_valid;
    logic       unit_end;
    logic       string_end;
  } utf8_byte_t;

  class utf8_scoreboard;
    utf8_byte_t expected_bytes[$];
    utf8_byte_t step_bytes[$];
    bit         held_high;
    logic [9:0] held_bits;
    bit         halted;
    int         mismatches;

    function void clear_state();
      held_high = 1'b0;
      held_bits = '0;
      halted    = 1'b0;
    endfunction

    function void push_byte(logic [7:0] b);
      utf8_byte_t e;
      e = '{b, 1'b1, 1'b0, 1'b0};
      step_bytes = {step_bytes, e};
    endfunction

    function void encode_point(logic [20:0] cp);
      if (cp < 21'h80) begin
        push_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        push_byte({3'b110, cp[10:6]});
        push_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        push_byte({4'b1110, cp[15:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end else begin
        push_byte({5'b11110, cp[20:18]});
        push_byte({2'b10, cp[17:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
    endfunction

    // Returns 1 unless the unit falls after a terminator.
    function bit note_unit(logic [15:0] unit, bit last);
      bit          is_high;
      bit          is_low;
      bit          paired;
      bit          live;
      int          k;
      logic [20:0] cp;
      utf8_byte_t  marker;
      is_high = unit >= 16'hD800 && unit <= 16'hDBFF;
      is_low  = unit >= 16'hDC00 && unit <= 16'hDFFF;
      paired  = 1'b0;
      live    = !halted;
      step_bytes.delete();
      if (!halted) begin
        if (held_high) begin
          if (is_low) begin
            cp = 21'h10000 + {held_bits, 10'b0} + {11'b0, unit[9:0]};
            encode_point(cp);
            paired = 1'b1;
          end else begin
            encode_point({5'b0, 6'b110110, held_bits});
          end
          held_high = 1'b0;
          held_bits = '0;
        end
        if (!paired) begin
          if (is_high && !last) begin
            held_high = 1'b1;
            held_bits = unit[9:0];
          end else if (unit == 16'h0000) begin
            halted = 1'b1;
          end else begin
            encode_point({5'b0, unit});
          end
        end
      end
      if (last) begin
        if (step_bytes.size() == 0) begin
          marker = '{8'h00, 1'b0, 1'b0, 1'b0};
          step_bytes = {step_bytes, marker};
        end
        k = step_bytes.size() - 1;
        step_bytes[k].string_end = 1'b1;
        clear_state();
      end
      if (step_bytes.size() > 0) begin
        k = step_bytes.size() - 1;
        step_bytes[k].unit_end = 1'b1;
      end
      expected_bytes = {expected_bytes, step_bytes};
      return live;
    endfunction

    task report(string field, logic [7:0] got, logic [7:0] want);
      $display("%0t: %s got %h, want %h", $time, field, got, want);
      mismatches++;
    endtask

    task check_byte(logic [7:0] data, logic dv, logic ue, logic se);
      utf8_byte_t want;
      if (expected_bytes.size() == 0) begin
        report("unexpected byte", data, 8'h00);
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) report("out_byte", data, want.data);
      if (dv !== want.data_valid) report("byte_valid", 8'(dv), 8'(want.data_valid));
      if (ue !== want.unit_end) report("last_of_item", 8'(ue), 8'(want.unit_end));
      if (se !== want.string_end) report("end_of_string", 8'(se), 8'(want.string_end));
    endtask
  endclass

  // bit 16 carries last_unit
  localparam logic [16:0] Directed[24] = '{
    17'h00041, 17'h0007F, 17'h00080, 17'h007FF, 17'h00800, 17'h0FFFF,
    17'h0D800, 17'h0DC00, 17'h0DBFF, 17'h0DFFF, 17'h0D83D, 17'h0E000,
    17'h0DC00, 17'h1DBFF, 17'h00001, 17'h0DABC, 17'h00000, 17'h0FFFF,
    17'h0D800, 17'h11234, 17'h10000, 17'h0D800, 17'h0D800, 17'h1DC01
  };

  logic clk = 1'b0;
  logic rst_n;
  int   send_burst;
  int   live_units;

  utf8_scoreboard board = new;

  utt_in_if  in_ch();
  utt_out_if out_ch();

  utf16_to_utf8_transcoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  task automatic send_unit(input logic [15:0] unit, input bit last);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(8, 24);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_unit <= unit;
    in_ch.last_unit <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (board.note_unit(unit, last)) live_units++;
  endtask

  task automatic send_string();
    int len;
    int kind;
    bit last;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        send_unit(16'($urandom_range(1, 16'h7F)), last);
      end else if (kind < 9) begin
        send_unit(16'($urandom_range(16'h80, 16'h7FF)), last);
      end else if (kind < 12) begin
        if ($urandom_range(0, 1)) send_unit(16'($urandom_range(16'h800, 16'hD7FF)), last);
        else send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last);
      end else if (kind < 16) begin
        send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
        send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
      end else if (kind < 18) begin
        send_unit(16'($urandom), last);
      end else if (kind == 18) begin
        send_unit(16'($urandom_range(16'hD800, 16'hDFFF)), last);
      end else begin
        send_unit($urandom_range(0, 3) == 0 ? 16'h0000 : 16'h0020, last);
      end
    end
  endtask

  initial begin
    send_burst = 0;
    live_units = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.code_unit <= '0;
    in_ch.last_unit <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 24; i++) send_unit(Directed[i][15:0], Directed[i][16]);
    while (live_units < 220) send_string();
    in_ch.valid <= 1'b0;
    while (board.expected_bytes.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int stall;
    int recv_burst;
    stall      = 0;
    recv_burst = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        board.check_byte(out_ch.out_byte, out_ch.byte_valid, out_ch.last_of_item,
                         out_ch.end_of_string);
        if (recv_burst > 0) begin
          stall = 0;
          recv_burst--;
        end else begin
          stall = $urandom_range(0, 6);
          if ($urandom_range(0, 15) == 0) recv_burst = $urandom_range(8, 24);
        end
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/utt_pkg.sv
rtl/utt_if.sv
rtl/utt_front.sv
rtl/utt_queue.sv
rtl/utt_back.sv
rtl/utf16_to_utf8_transcoder.sv
rtl/utt_checker.sv
verif/tb.sv
